// ----- sv/ddo_pkg.sv -----
// shared constants, widths and tables for the differential drive odometry unit
package ddo_pkg;

  // default number of cordic iterations and the length of the arctangent table
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ATAN_N           = 32;
  localparam int IDX_W            = 5;

  // serial arithmetic unit widths
  localparam int MA_W  = 40;  // multiplicand
  localparam int MB_W  = 33;  // multiplier
  localparam int PR_W  = 73;  // product
  localparam int DN_W  = 63;  // dividend and quotient
  localparam int DD_W  = 32;  // divisor and remainder
  localparam int CNT_W = 6;   // step counter, holds up to DN_W - 1

  // cordic datapath widths
  localparam int Z_W  = 36;
  localparam int XY_W = 36;

  // arithmetic unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_DPT  = 2'd0;
  localparam logic [1:0] REG_LOFS = 2'd1;
  localparam logic [1:0] REG_ROFS = 2'd2;

  // reset values of the configuration registers
  localparam logic [23:0] DPT_RST  = 24'd603936;
  localparam logic [23:0] LOFS_RST = 24'd323584;
  localparam logic [23:0] ROFS_RST = 24'd323584;

  // angle constants in q25 radians, gain in q30, degrees per radian in q24
  localparam int TWO_PI_Q25      = 210828714;
  localparam int PI_Q25          = 105414357;
  localparam int HALF_PI_Q25     = 52707179;
  localparam int CORDIC_GAIN_Q30 = 32'h26DD3B6A;
  localparam int DEG_PER_RAD_Q24 = 961263669;

  // arctangent of 2^-i in q30
  function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ddo_arith.sv -----
// bit serial signed multiplier and unsigned restoring divider sharing one step counter
module ddo_arith (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               op,
  input  logic signed [ddo_pkg::MA_W-1:0]    a,
  input  logic signed [ddo_pkg::MB_W-1:0]    b,
  input  logic        [ddo_pkg::DN_W-1:0]    n,
  input  logic        [ddo_pkg::DD_W-1:0]    d,
  output logic                               done,
  output logic signed [ddo_pkg::PR_W-1:0]    prod,
  output logic        [ddo_pkg::DN_W-1:0]    quo,
  output logic        [ddo_pkg::DD_W-1:0]    rem
);
  import ddo_pkg::*;

  logic                    busy;
  logic                    is_div;
  logic [CNT_W-1:0]        cnt;
  logic signed [PR_W-1:0]  mcand;
  logic [MB_W-1:0]         mplier;
  logic [DN_W-1:0]         num;
  logic [DD_W-1:0]         d_r;
  logic signed [PR_W-1:0]  addend;
  logic signed [PR_W-1:0]  acc_next;
  logic                    last_mul;
  logic                    last;
  logic [DD_W:0]           trial;
  logic [DD_W:0]           trial_sub;
  logic                    fits;

  // one multiplier bit or one quotient bit per cycle
  always_comb begin
    last_mul  = (cnt == CNT_W'(MB_W - 1));
    last      = is_div ? (cnt == CNT_W'(DN_W - 1)) : last_mul;
    addend    = mplier[0] ? mcand : '0;
    // the top multiplier bit carries negative weight
    acc_next  = last_mul ? (prod - addend) : (prod + addend);
    trial     = {rem, num[DN_W-1]};
    trial_sub = trial - {1'b0, d_r};
    fits      = (trial >= {1'b0, d_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      is_div <= OP_MUL;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        is_div <= op;
        cnt    <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= {{(PR_W-MA_W){a[MA_W-1]}}, a};
      mplier <= b;
      prod   <= '0;
      num    <= n;
      d_r    <= d;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      if (is_div == OP_DIV) begin
        num <= {num[DN_W-2:0], 1'b0};
        quo <= {quo[DN_W-2:0], fits};
        rem <= fits ? trial_sub[DD_W-1:0] : trial[DD_W-1:0];
      end else begin
        prod   <= acc_next;
        mcand  <= {mcand[PR_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[MB_W-1:1]};
      end
    end
  end

endmodule

// ----- sv/ddo_cordic.sv -----
// iterative rotation mode cordic, one micro rotation per cycle
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ddo_pkg::Z_W-1:0]     z0,
  input  logic                               neg,
  output logic                               done,
  output logic signed [ddo_pkg::XY_W-1:0]    sin_o,
  output logic signed [ddo_pkg::XY_W-1:0]    cos_o
);
  import ddo_pkg::*;

  localparam int ITERS = (STEPS < ATAN_N) ? STEPS : ATAN_N;

  logic                    busy;
  logic [IDX_W-1:0]        cnt;
  logic                    neg_r;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [Z_W-1:0]   at;

  // shifted terms and table angle for this iteration
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = Z_W'(atan_q30(cnt));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == IDX_W'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // rotation
  always_ff @(posedge clk) begin
    if (start) begin
      x     <= XY_W'(CORDIC_GAIN_Q30);
      y     <= '0;
      z     <= z0;
      neg_r <= neg;
    end else if (busy) begin
      if (!z[Z_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  // half turn folded back in
  assign sin_o = neg_r ? -y : y;
  assign cos_o = neg_r ? -x : x;

endmodule

// ----- sv/differential_drive_odometry_unit.sv -----
// differential drive arc odometry: pose update from absolute wheel encoder positions
// One transaction in yields one pose transaction out. Each item is worked through in
// sequence on a single bit serial unit and a cordic of min(CORDIC_STEPS, 32) iterations
// that runs once or twice. An item takes longest when a larger heading change needs the
// sin(h)/h division, less for a small heading change and least with a zero wheel base. The
// time per item is set almost wholly by the shared multiply and divide unit. The input is
// ready again as soon as the previous result sits in the output register, so a result
// waiting on the master side holds nothing up until the next result is ready. Configuration
// writes land at once and are meant for idle periods only.
module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // left_position, right_position
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // pos_x, pos_y, heading_rad, heading_deg
  output logic [0:0]   m_axis_tuser,   // overflow
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata
);
  import ddo_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DL    = 4'd1;
  localparam logic [3:0] S_DR    = 4'd2;
  localparam logic [3:0] S_DTH   = 4'd3;
  localparam logic [3:0] S_DSEL  = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SQDIV = 4'd6;
  localparam logic [3:0] S_RED   = 4'd7;
  localparam logic [3:0] S_COR   = 4'd8;
  localparam logic [3:0] S_RDIV  = 4'd9;
  localparam logic [3:0] S_CHM   = 4'd10;
  localparam logic [3:0] S_C16   = 4'd11;
  localparam logic [3:0] S_DX    = 4'd12;
  localparam logic [3:0] S_DY    = 4'd13;
  localparam logic [3:0] S_DEG   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam logic signed [59:0] CHORD_LIM = 60'sd70368744177664;

  // configuration and pose state
  logic [23:0]         dpt;
  logic [23:0]         lofs;
  logic [23:0]         rofs;
  logic signed [31:0]  last_l;
  logic signed [31:0]  last_r;
  logic signed [31:0]  pose_x;
  logic signed [31:0]  pose_y;
  logic signed [31:0]  pose_th;

  // per item working registers
  logic [3:0]          state;
  logic signed [32:0]  d_r;
  logic signed [57:0]  dl;
  logic                dneg;
  logic signed [31:0]  dth;
  logic signed [31:0]  ratio;
  logic signed [33:0]  ang;
  logic                phase;
  logic signed [39:0]  chord16;
  logic signed [XY_W-1:0] cs;
  logic                ov;
  logic [31:0]         deg;

  // arithmetic unit and cordic hookup
  logic                   ar_start;
  logic                   ar_op;
  logic signed [MA_W-1:0] ar_a;
  logic signed [MB_W-1:0] ar_b;
  logic [DN_W-1:0]        ar_n;
  logic [DD_W-1:0]        ar_d;
  logic                   ar_done;
  logic signed [PR_W-1:0] ar_prod;
  logic [DN_W-1:0]        ar_quo;
  logic [DD_W-1:0]        ar_rem;
  logic                   cor_start;
  logic signed [Z_W-1:0]  cor_z;
  logic                   cor_neg;
  logic                   cor_done;
  logic signed [XY_W-1:0] cor_sin;
  logic signed [XY_W-1:0] cor_cos;

  // combinational helpers
  logic signed [31:0]  in_l;
  logic signed [31:0]  in_r;
  logic signed [32:0]  d_l_w;
  logic signed [32:0]  d_r_w;
  logic signed [58:0]  diff_w;
  logic [58:0]         mag_w;
  logic [46:0]         magc;
  logic [24:0]         base;
  logic [31:0]         q_c;
  logic                small_ang;
  logic signed [30:0]  r0;
  logic signed [30:0]  r1;
  logic signed [30:0]  r2;
  logic signed [30:0]  r3;
  logic                fold;
  logic signed [Z_W-1:0] z_w;
  logic [XY_W-1:0]     s_mag;
  logic [31:0]         dth_mag;
  logic [31:0]         qm;
  logic signed [59:0]  chord_w;
  logic signed [47:0]  cc;
  logic                chord_sat;
  logic signed [33:0]  phi;
  logic signed [45:0]  sum_p;
  logic signed [31:0]  sat_p;
  logic                hit_p;
  logic signed [32:0]  th_sum;
  logic signed [31:0]  th_sat;
  logic                th_hit;

  ddo_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (ar_start),
    .op    (ar_op),
    .a     (ar_a),
    .b     (ar_b),
    .n     (ar_n),
    .d     (ar_d),
    .done  (ar_done),
    .prod  (ar_prod),
    .quo   (ar_quo),
    .rem   (ar_rem)
  );

  ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .z0    (cor_z),
    .neg   (cor_neg),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    in_l  = $signed(s_axis_tdata[31:0]);
    in_r  = $signed(s_axis_tdata[63:32]);
    d_l_w = $signed({in_l[31], in_l}) - $signed({last_l[31], last_l});
    d_r_w = $signed({in_r[31], in_r}) - $signed({last_r[31], last_r});
    base  = {1'b0, lofs} + {1'b0, rofs};

    // wheel difference magnitude, clamped
    diff_w = $signed({ar_prod[57], ar_prod[57:0]}) - $signed({dl[57], dl});
    mag_w  = diff_w[58] ? 59'(-diff_w) : 59'(diff_w);
    magc   = (mag_w > 59'(CHORD_LIM)) ? 47'(CHORD_LIM) : mag_w[46:0];

    // heading change quotient clamped to 2^31
    q_c       = (ar_quo > 63'h80000000) ? 32'h80000000 : ar_quo[31:0];
    small_ang = (dth > -32'sd1048576) && (dth < 32'sd1048576);

    // angle reduction into [-pi/2, pi/2] with a half turn flag
    r0 = ang[33] ? -$signed({1'b0, ar_rem[29:0]}) : $signed({1'b0, ar_rem[29:0]});
    r1 = (r0 >= 31'(PI_Q25)) ? 31'(r0 - 31'(TWO_PI_Q25)) : r0;
    r2 = (r1 < -31'(PI_Q25)) ? 31'(r1 + 31'(TWO_PI_Q25)) : r1;
    fold = 1'b0;
    r3   = r2;
    if (r2 > 31'(HALF_PI_Q25)) begin
      r3   = 31'(r2 - 31'(PI_Q25));
      fold = 1'b1;
    end else if (r2 < -31'(HALF_PI_Q25)) begin
      r3   = 31'(r2 + 31'(PI_Q25));
      fold = 1'b1;
    end
    z_w = {r3, 5'b0};

    // sin(h)/h for larger angles
    s_mag   = cor_sin[XY_W-1] ? XY_W'(-cor_sin) : XY_W'(cor_sin);
    dth_mag = dth[31] ? 32'(-dth) : 32'(dth);
    qm      = (ar_quo > 63'h40000000) ? 32'h40000000 : ar_quo[31:0];

    // chord before scaling, clamped
    chord_w   = $signed({{2{dl[57]}}, dl}) + $signed(ar_prod[75-16-1:16]);
    chord_sat = (chord_w > CHORD_LIM) || (chord_w < -CHORD_LIM);
    if (chord_w > CHORD_LIM) begin
      cc = 48'(CHORD_LIM);
    end else if (chord_w < -CHORD_LIM) begin
      cc = 48'(-CHORD_LIM);
    end else begin
      cc = chord_w[47:0];
    end

    phi = $signed({pose_th[31], pose_th, 1'b0}) + $signed({{2{dth[31]}}, dth});

    // pose coordinate update, x or y by state
    sum_p = (state == S_DX) ? $signed({{14{pose_x[31]}}, pose_x}) : $signed({{14{pose_y[31]}}, pose_y});
    sum_p = sum_p + $signed(ar_prod[PR_W-1:28]);
    hit_p = (sum_p > 46'sd2147483647) || (sum_p < -46'sd2147483648);
    if (sum_p > 46'sd2147483647) begin
      sat_p = 32'sh7FFFFFFF;
    end else if (sum_p < -46'sd2147483648) begin
      sat_p = 32'sh80000000;
    end else begin
      sat_p = sum_p[31:0];
    end

    th_sum = $signed({pose_th[31], pose_th}) + $signed({dth[31], dth});
    th_hit = (th_sum[32] != th_sum[31]);
    th_sat = th_hit ? (th_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : th_sum[31:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dpt  <= DPT_RST;
      lofs <= LOFS_RST;
      rofs <= ROFS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DPT:  dpt  <= cfg_wdata;
        REG_LOFS: lofs <= cfg_wdata;
        REG_ROFS: rofs <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ar_start      <= 1'b0;
      cor_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      last_l        <= '0;
      last_r        <= '0;
      pose_x        <= '0;
      pose_y        <= '0;
      pose_th       <= '0;
      ov            <= 1'b0;
    end else begin
      ar_start  <= 1'b0;
      cor_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            d_r      <= d_r_w;
            last_l   <= in_l;
            last_r   <= in_r;
            ov       <= 1'b0;
            ar_op    <= OP_MUL;
            ar_a     <= {16'b0, dpt};
            ar_b     <= d_l_w;
            ar_start <= 1'b1;
            state    <= S_DL;
          end
        end
        S_DL: begin
          if (ar_done) begin
            dl       <= ar_prod[57:0];
            ar_op    <= OP_MUL;
            ar_a     <= {16'b0, dpt};
            ar_b     <= d_r;
            ar_start <= 1'b1;
            state    <= S_DR;
          end
        end
        S_DR: begin
          if (ar_done) begin
            dneg <= diff_w[58];
            if (base == '0) begin
              dth   <= '0;
              state <= S_DSEL;
            end else begin
              ar_op    <= OP_DIV;
              ar_n     <= {magc, 16'b0};
              ar_d     <= {7'b0, base};
              ar_start <= 1'b1;
              state    <= S_DTH;
            end
          end
        end
        S_DTH: begin
          if (ar_done) begin
            if (dneg) begin
              dth <= -$signed(q_c);
            end else if (q_c == 32'h80000000) begin
              dth <= 32'sh7FFFFFFF;
              ov  <= 1'b1;
            end else begin
              dth <= $signed(q_c);
            end
            state <= S_DSEL;
          end
        end
        S_DSEL: begin
          ar_start <= 1'b1;
          if (small_ang) begin
            ar_op <= OP_MUL;
            ar_a  <= MA_W'(dth);
            ar_b  <= MB_W'(dth);
            state <= S_SQ;
          end else begin
            ang   <= 34'(dth);
            phase <= 1'b0;
            ar_op <= OP_DIV;
            ar_n  <= {31'b0, dth_mag};
            ar_d  <= DD_W'(TWO_PI_Q25);
            state <= S_RED;
          end
        end
        S_SQ: begin
          if (ar_done) begin
            ar_op    <= OP_DIV;
            ar_n     <= ar_prod[DN_W-1:0];
            ar_d     <= 32'd6291456;
            ar_start <= 1'b1;
            state    <= S_SQDIV;
          end
        end
        S_SQDIV: begin
          if (ar_done) begin
            ratio    <= 32'sh40000000 - $signed(ar_quo[31:0]);
            ar_op    <= OP_MUL;
            ar_a     <= {16'b0, lofs};
            ar_b     <= MB_W'(dth);
            ar_start <= 1'b1;
            state    <= S_CHM;
          end
        end
        S_RED: begin
          if (ar_done) begin
            cor_z     <= z_w;
            cor_neg   <= fold;
            cor_start <= 1'b1;
            state     <= S_COR;
          end
        end
        S_COR: begin
          if (cor_done) begin
            ar_start <= 1'b1;
            if (!phase) begin
              dneg  <= cor_sin[XY_W-1] ^ dth[31];
              ar_op <= OP_DIV;
              ar_n  <= DN_W'(s_mag) << 25;
              ar_d  <= dth_mag;
              state <= S_RDIV;
            end else begin
              cs    <= cor_cos;
              ar_op <= OP_MUL;
              ar_a  <= chord16;
              ar_b  <= MB_W'(cor_sin >>> 6);
              state <= S_DX;
            end
          end
        end
        S_RDIV: begin
          if (ar_done) begin
            ratio    <= dneg ? -$signed(qm) : $signed(qm);
            ar_op    <= OP_MUL;
            ar_a     <= {16'b0, lofs};
            ar_b     <= MB_W'(dth);
            ar_start <= 1'b1;
            state    <= S_CHM;
          end
        end
        S_CHM: begin
          if (ar_done) begin
            if (chord_sat) begin
              ov <= 1'b1;
            end
            ar_op    <= OP_MUL;
            ar_a     <= cc[47:8];
            ar_b     <= MB_W'(ratio >>> 6);
            ar_start <= 1'b1;
            state    <= S_C16;
          end
        end
        S_C16: begin
          if (ar_done) begin
            chord16  <= ar_prod[63:24];
            ang      <= phi;
            phase    <= 1'b1;
            ar_op    <= OP_DIV;
            ar_n     <= DN_W'(phi[33] ? 34'(-phi) : 34'(phi));
            ar_d     <= DD_W'(TWO_PI_Q25);
            ar_start <= 1'b1;
            state    <= S_RED;
          end
        end
        S_DX: begin
          if (ar_done) begin
            pose_x <= sat_p;
            if (hit_p) begin
              ov <= 1'b1;
            end
            ar_op    <= OP_MUL;
            ar_a     <= chord16;
            ar_b     <= MB_W'(cs >>> 6);
            ar_start <= 1'b1;
            state    <= S_DY;
          end
        end
        S_DY: begin
          if (ar_done) begin
            pose_y  <= sat_p;
            pose_th <= th_sat;
            if (hit_p || th_hit) begin
              ov <= 1'b1;
            end
            ar_op    <= OP_MUL;
            ar_a     <= MA_W'(DEG_PER_RAD_Q24);
            ar_b     <= MB_W'(th_sat);
            ar_start <= 1'b1;
            state    <= S_DEG;
          end
        end
        S_DEG: begin
          if (ar_done) begin
            deg   <= ar_prod[62:31];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {deg, pose_th, pose_y, pose_x};
            m_axis_tuser  <= ov;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // arithmetic results only arrive while the sequencer waits for one
  a_ar_done: assert property (@(posedge clk) disable iff (rst)
    ar_done |-> (state != S_IDLE && state != S_OUT && state != S_COR && state != S_DSEL))
    else $error("arithmetic result with no operation pending");

  // cordic results only arrive in the cordic wait state
  a_cor_done: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_COR))
    else $error("cordic result with no rotation pending");

  // a result is only loaded after the degree conversion
  a_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && $past(state) != S_OUT) |-> ($past(state) == S_DEG))
    else $error("output stage entered out of order");

endmodule
